[hdl/i2cmbe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared widths, operation codes and the records passed between the
// front end, the engine and the result queue.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int MAX_BITS = 16;
  localparam int DATA_W   = 16;
  localparam int CNT_W    = 5;
  localparam int IDX_W    = $clog2(MAX_BITS);
  localparam int HP_W     = 16;
  localparam int OP_W     = 3;

  localparam logic [HP_W-1:0] HP_RESET = HP_W'(4);

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  // decoded tick: unknown codes already folded to OP_TICK, count clamped
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] write_data;
    logic [CNT_W-1:0]  bit_count;
    logic              sda_in;
  } cmd_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_drive_low;
    logic              busy_res;
    logic [DATA_W-1:0] read_data;
    logic              ack_received;
    logic              done_res;
  } res_t;

endpackage

[hdl/i2cmbe_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master front end
// Decodes each input tick and holds it in a two-entry command queue that
// the engine drains.
// ----------------------------------------------------------------------------
module i2cmbe_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [i2cmbe_pkg::OP_W-1:0]   in_operation,
  input  logic [i2cmbe_pkg::DATA_W-1:0] in_write_data,
  input  logic [i2cmbe_pkg::CNT_W-1:0]  in_bit_count,
  input  logic                        in_sda_in,
  output logic                        cmd_valid,
  output i2cmbe_pkg::cmd_t            cmd,
  input  logic                        cmd_pop
);
  import i2cmbe_pkg::*;

  cmd_t       dec;
  cmd_t       q_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       push_ok, pop_ok;

  always_comb begin
    dec.write_data = in_write_data;
    dec.sda_in     = in_sda_in;
    case (in_operation)
      OP_START: dec.op = OP_START;
      OP_STOP:  dec.op = OP_STOP;
      OP_WRITE: dec.op = OP_WRITE;
      OP_READ:  dec.op = OP_READ;
      default:  dec.op = OP_TICK;
    endcase
    if (in_bit_count == '0) begin
      dec.bit_count = CNT_W'(1);
    end else if (in_bit_count > CNT_W'(MAX_BITS)) begin
      dec.bit_count = CNT_W'(MAX_BITS);
    end else begin
      dec.bit_count = in_bit_count;
    end
  end

  assign in_full   = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;

  always_comb begin
    count_nxt = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 2'd1;
    end else if (!push_ok && pop_ok) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_ok) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

[hdl/i2cmbe_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master result queue
// Two-entry queue of per-tick results between the engine and the reader.
// ----------------------------------------------------------------------------
module i2cmbe_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_push,
  input  i2cmbe_pkg::res_t res_in,
  output logic             res_full,
  output logic             out_empty,
  input  logic             out_pop,
  output i2cmbe_pkg::res_t res_out
);
  import i2cmbe_pkg::*;

  res_t       q_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       push_ok, pop_ok;

  assign res_full  = (count_r == 2'd2);
  assign out_empty = (count_r == 2'd0);
  assign res_out   = q_r[rd_ptr_r];
  assign push_ok   = res_push && !res_full;
  assign pop_ok    = out_pop && !out_empty;

  always_comb begin
    count_nxt = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 2'd1;
    end else if (!push_ok && pop_ok) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_ok) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= res_in;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result queue count out of range");
`endif

endmodule

[hdl/i2cmbe_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bus engine
// Runs the start/stop/write/read phase machine, one queued tick per clock
// while the result queue has room, and pushes each tick's line state into it.
// ----------------------------------------------------------------------------
module i2cmbe_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_write_en,
  input  logic [i2cmbe_pkg::HP_W-1:0] cfg_write_data,
  input  logic                        cmd_valid,
  input  i2cmbe_pkg::cmd_t            cmd,
  output logic                        cmd_pop,
  input  logic                        res_full,
  output logic                        res_push,
  output i2cmbe_pkg::res_t            res
);
  import i2cmbe_pkg::*;

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_START_REL  = 4'd1;
  localparam logic [3:0] PH_START_PULL = 4'd2;
  localparam logic [3:0] PH_START_LOW  = 4'd3;
  localparam logic [3:0] PH_STOP_LOW   = 4'd4;
  localparam logic [3:0] PH_STOP_HIGH  = 4'd5;
  localparam logic [3:0] PH_WR_LOW     = 4'd6;
  localparam logic [3:0] PH_WR_HIGH    = 4'd7;
  localparam logic [3:0] PH_ACK_LOW    = 4'd8;
  localparam logic [3:0] PH_ACK_HIGH   = 4'd9;
  localparam logic [3:0] PH_RD_LOW     = 4'd10;
  localparam logic [3:0] PH_RD_HIGH    = 4'd11;
  localparam logic [3:0] PH_MACK_LOW   = 4'd12;
  localparam logic [3:0] PH_MACK_HIGH  = 4'd13;

  logic [HP_W-1:0]   half_period_r;
  logic [3:0]        phase_r, phase_nxt;
  logic [CNT_W-1:0]  bits_left_r, bits_left_nxt;
  logic [DATA_W-1:0] shift_word_r, shift_word_nxt;
  logic [HP_W-1:0]   tick_count_r, tick_count_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_low_r, sda_low_nxt;
  logic              ack_r, ack_nxt;
  logic [DATA_W-1:0] rx_word_r, rx_word_nxt;
  logic              done;
  logic              fire;
  logic [HP_W-1:0]   limit;
  logic [HP_W:0]     tick_sum;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  left_m2;

  assign fire     = cmd_valid && !res_full;
  assign cmd_pop  = fire;
  assign res_push = fire;

  assign limit    = (half_period_r == '0) ? HP_W'(1) : half_period_r;
  assign tick_sum = {1'b0, tick_count_r} + (HP_W+1)'(1);
  assign cnt_m1   = cmd.bit_count - CNT_W'(1);
  // next bit to send after a high segment: index bits_left - 2
  assign left_m2  = bits_left_r - CNT_W'(2);

  always_comb begin
    phase_nxt      = phase_r;
    bits_left_nxt  = bits_left_r;
    shift_word_nxt = shift_word_r;
    tick_count_nxt = tick_count_r;
    scl_nxt        = scl_r;
    sda_low_nxt    = sda_low_r;
    ack_nxt        = ack_r;
    rx_word_nxt    = rx_word_r;
    done           = 1'b0;
    if (phase_r == PH_IDLE) begin
      tick_count_nxt = '0;
      case (cmd.op)
        OP_START: begin
          phase_nxt = PH_START_REL; scl_nxt = 1'b1; sda_low_nxt = 1'b0;
        end
        OP_STOP: begin
          phase_nxt = PH_STOP_LOW; scl_nxt = 1'b0; sda_low_nxt = 1'b1;
        end
        OP_WRITE: begin
          shift_word_nxt = cmd.write_data;
          bits_left_nxt  = cmd.bit_count;
          phase_nxt      = PH_WR_LOW;
          scl_nxt        = 1'b0;
          sda_low_nxt    = ~cmd.write_data[cnt_m1[IDX_W-1:0]];
        end
        OP_READ: begin
          shift_word_nxt = '0;
          bits_left_nxt  = cmd.bit_count;
          phase_nxt      = PH_RD_LOW;
          scl_nxt        = 1'b0;
          sda_low_nxt    = 1'b0;
        end
        default: begin
          tick_count_nxt = tick_count_r;
        end
      endcase
    end else begin
      tick_count_nxt = tick_sum[HP_W-1:0];
      if (tick_sum >= {1'b0, limit}) begin
        tick_count_nxt = '0;
        case (phase_r)
          PH_START_REL: begin
            phase_nxt = PH_START_PULL; scl_nxt = 1'b1; sda_low_nxt = 1'b1;
          end
          PH_START_PULL: begin
            phase_nxt = PH_START_LOW; scl_nxt = 1'b0; sda_low_nxt = 1'b1;
          end
          PH_START_LOW: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b0; sda_low_nxt = 1'b1; done = 1'b1;
          end
          PH_STOP_LOW: begin
            phase_nxt = PH_STOP_HIGH; scl_nxt = 1'b1; sda_low_nxt = 1'b1;
          end
          PH_STOP_HIGH: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b1; sda_low_nxt = 1'b0; done = 1'b1;
          end
          PH_WR_LOW: begin
            phase_nxt = PH_WR_HIGH; scl_nxt = 1'b1;
          end
          PH_WR_HIGH: begin
            bits_left_nxt = bits_left_r - CNT_W'(1);
            scl_nxt       = 1'b0;
            if (bits_left_r > CNT_W'(1)) begin
              phase_nxt   = PH_WR_LOW;
              sda_low_nxt = ~shift_word_r[left_m2[IDX_W-1:0]];
            end else begin
              phase_nxt   = PH_ACK_LOW;
              sda_low_nxt = 1'b0;
            end
          end
          PH_ACK_LOW: begin
            phase_nxt = PH_ACK_HIGH; scl_nxt = 1'b1; sda_low_nxt = 1'b0;
          end
          PH_ACK_HIGH: begin
            ack_nxt   = ~cmd.sda_in;
            phase_nxt = PH_IDLE; scl_nxt = 1'b1; sda_low_nxt = 1'b0; done = 1'b1;
          end
          PH_RD_LOW: begin
            phase_nxt = PH_RD_HIGH; scl_nxt = 1'b1; sda_low_nxt = 1'b0;
          end
          PH_RD_HIGH: begin
            shift_word_nxt = {shift_word_r[DATA_W-2:0], cmd.sda_in};
            bits_left_nxt  = bits_left_r - CNT_W'(1);
            scl_nxt        = 1'b0;
            if (bits_left_r > CNT_W'(1)) begin
              phase_nxt   = PH_RD_LOW;
              sda_low_nxt = 1'b0;
            end else begin
              rx_word_nxt = {shift_word_r[DATA_W-2:0], cmd.sda_in};
              phase_nxt   = PH_MACK_LOW;
              sda_low_nxt = 1'b1;
            end
          end
          PH_MACK_LOW: begin
            phase_nxt = PH_MACK_HIGH; scl_nxt = 1'b1; sda_low_nxt = 1'b1;
          end
          PH_MACK_HIGH: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b1; sda_low_nxt = 1'b0; done = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b1; sda_low_nxt = 1'b0; done = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    res.scl_level     = scl_nxt;
    res.sda_drive_low = sda_low_nxt;
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.read_data     = rx_word_nxt;
    res.ack_received  = ack_nxt;
    res.done_res      = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HP_RESET;
    end else if (cfg_write_en) begin
      half_period_r <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bits_left_r  <= '0;
      shift_word_r <= '0;
      tick_count_r <= '0;
      scl_r        <= 1'b1;
      sda_low_r    <= 1'b0;
      ack_r        <= 1'b0;
      rx_word_r    <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      bits_left_r  <= bits_left_nxt;
      shift_word_r <= shift_word_nxt;
      tick_count_r <= tick_count_nxt;
      scl_r        <= scl_nxt;
      sda_low_r    <= sda_low_nxt;
      ack_r        <= ack_nxt;
      rx_word_r    <= rx_word_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.done_res |-> !res.busy_res)
    else $error("command completes while still busy");
  a_bits_left_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WR_HIGH || phase_r == PH_RD_HIGH) |-> bits_left_r != '0)
    else $error("data phase with no bits left");
  a_rx_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && phase_r == PH_RD_HIGH) |=> $stable(rx_word_r))
    else $error("received word changed outside a read bit");
  a_start_entry: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == PH_IDLE && cmd.op == OP_START |=> phase_r == PH_START_REL)
    else $error("start command not taken");
`endif

endmodule

[hdl/i2c_master_bit_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine
// Path: a tick is written into the front queue register, taken by the engine
//   from there, and its result is written into the result queue register
//   before it shows on the out_ ports; a full result queue holds it back.
// Throughput: one tick per clock while a tick is queued and the result queue has room.
// Reset (synchronous, rst_n low): queues empty, bus released, half period 4.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic [i2cmbe_pkg::HP_W-1:0]   cfg_write_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [i2cmbe_pkg::OP_W-1:0]   in_operation,
  input  logic [i2cmbe_pkg::DATA_W-1:0] in_write_data,
  input  logic [i2cmbe_pkg::CNT_W-1:0]  in_bit_count,
  input  logic                          in_sda_in,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_scl_level,
  output logic                          out_sda_drive_low,
  output logic                          out_busy_res,
  output logic [i2cmbe_pkg::DATA_W-1:0] out_read_data,
  output logic                          out_ack_received,
  output logic                          out_done_res
);
  import i2cmbe_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  logic res_full, res_push;
  res_t res, res_out;

  i2cmbe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_operation  (in_operation),
    .in_write_data (in_write_data),
    .in_bit_count  (in_bit_count),
    .in_sda_in     (in_sda_in),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  i2cmbe_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .res_full       (res_full),
    .res_push       (res_push),
    .res            (res)
  );

  i2cmbe_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_in    (res),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res_out   (res_out)
  );

  assign out_scl_level     = res_out.scl_level;
  assign out_sda_drive_low = res_out.sda_drive_low;
  assign out_busy_res      = res_out.busy_res;
  assign out_read_data     = res_out.read_data;
  assign out_ack_received  = res_out.ack_received;
  assign out_done_res      = res_out.done_res;

endmodule
